// ===== hdl/bpc_pkg.sv =====
// Package for the button press classifier: widths, class and event codes, register indexes.
`default_nettype none

package bpc_pkg;

  // Tick and hold counter width
  localparam int COUNT_WIDTH = 16;
  // Configuration register data width
  localparam int CFG_W       = 16;
  // Configuration index width (leaves room for indexes beyond the register list)
  localparam int CFG_IDX_W   = 2;
  // Width for comparing counters against register values
  localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CFG_W-1:0]       cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CMP_W-1:0]       cmp_t;
  typedef logic [2:0]             code_t;

  // Register indexes
  localparam cfg_idx_t REG_SAMPLE_PERIOD  = 2'd0;
  localparam cfg_idx_t REG_LONG_THRESHOLD = 2'd1;

  // Register reset values
  localparam cfg_word_t SAMPLE_PERIOD_RST  = 16'd10;
  localparam cfg_word_t LONG_THRESHOLD_RST = 16'd1000;

  // Classification codes
  localparam code_t CLS_NONE      = 3'd0;
  localparam code_t CLS_RELEASED  = 3'd1;
  localparam code_t CLS_PRESSED   = 3'd2;
  localparam code_t CLS_PRESS_REL = 3'd3;
  localparam code_t CLS_LONG      = 3'd4;

  // Event codes
  localparam code_t EV_NONE      = 3'd0;
  localparam code_t EV_PRESSED   = 3'd1;
  localparam code_t EV_RELEASED  = 3'd2;
  localparam code_t EV_PRESS_REL = 3'd3;
  localparam code_t EV_LONG      = 3'd4;

  // Counter saturation value
  localparam count_t COUNT_MAX = '1;

  // One result beat; the last member lands in the lowest bits
  typedef struct packed {
    logic  sampled_now;
    code_t current_class;
    code_t event_raised;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/button_press_classifier.sv =====
// Top level of the button press classifier: tick counter, class update and output buffer.
`default_nettype none

// Each input beat is one time tick carrying the raw active-low button pin in
// in_tdata[0]. Every sample_period ticks the pin is sampled and a five-valued
// classification (none, released, pressed, pressed_then_released, long_pressed)
// is updated; every tick yields one result beat with the event raised, the class
// after the update and a sampled flag. The block takes one tick per clock cycle
// while the skid stage is empty: the class and both counters update in the cycle
// a tick is accepted, and the result lands in an output register backed by a
// one-entry skid stage, so input keeps flowing for one more beat while the output
// is stalled. Configuration writes are always accepted and take effect on the next
// tick; write them only while no tick is in flight.

module button_press_classifier
  import bpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  // Input tick channel
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire logic [7:0] in_tdata,   // [0] pin_level, [7:1] zero
  // Result channel
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output logic [7:0]     out_tdata,   // [2:0] event_raised, [5:3] current_class,
                                      // [6] sampled_now, [7] zero
  // Configuration write channel
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire cfg_idx_t  cfg_index,
  input  wire cfg_word_t cfg_data
);

  // Configuration registers
  cfg_word_t sample_period_r;
  cfg_word_t long_threshold_r;

  // Classification state
  code_t  press_class_r,  press_class_nxt;
  count_t sample_count_r, sample_count_nxt;
  count_t hold_count_r,   hold_count_nxt;

  // Output register and skid stage
  logic    out_valid_r,  out_valid_nxt;
  result_t out_data_r,   out_data_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_data_r,  skid_data_nxt;

  logic    in_acc;
  logic    pin_level;
  count_t  sc_inc, hc_inc;
  logic    do_sample;
  result_t res;

  assign cfg_ready = 1'b1;
  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;
  assign pin_level = in_tdata[0];

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r  <= SAMPLE_PERIOD_RST;
      long_threshold_r <= LONG_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SAMPLE_PERIOD) begin
        sample_period_r <= cfg_data;
      end else if (cfg_index == REG_LONG_THRESHOLD) begin
        long_threshold_r <= cfg_data;
      end
    end
  end

  // Advance both counters with saturation and decide on a sample
  assign sc_inc    = (sample_count_r == COUNT_MAX) ? COUNT_MAX : sample_count_r + 1'b1;
  assign hc_inc    = (hold_count_r == COUNT_MAX) ? COUNT_MAX : hold_count_r + 1'b1;
  assign do_sample = cmp_t'(sc_inc) >= cmp_t'(sample_period_r);

  // Update the classification for one tick
  always_comb begin
    code_t ev;
    ev               = EV_NONE;
    press_class_nxt  = press_class_r;
    hold_count_nxt   = hc_inc;
    sample_count_nxt = do_sample ? '0 : sc_inc;
    if (do_sample) begin
      if (pin_level) begin
        if (press_class_r == CLS_PRESSED) begin
          press_class_nxt = CLS_PRESS_REL;
          ev              = EV_PRESS_REL;
        end else if (press_class_r != CLS_RELEASED && press_class_r != CLS_PRESS_REL) begin
          press_class_nxt = CLS_RELEASED;
          ev              = EV_RELEASED;
        end
      end else begin
        if (press_class_r == CLS_RELEASED || press_class_r == CLS_PRESS_REL) begin
          press_class_nxt = CLS_PRESSED;
          hold_count_nxt  = '0;
          ev              = EV_PRESSED;
        end else if (press_class_r == CLS_PRESSED &&
                     cmp_t'(hc_inc) > cmp_t'(long_threshold_r)) begin
          press_class_nxt = CLS_LONG;
          ev              = EV_LONG;
        end
      end
    end
    res.event_raised  = ev;
    res.current_class = press_class_nxt;
    res.sampled_now   = do_sample;
  end

  // Hold state unless a tick is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_class_r  <= CLS_NONE;
      sample_count_r <= '0;
      hold_count_r   <= '0;
    end else if (in_acc) begin
      press_class_r  <= press_class_nxt;
      sample_count_r <= sample_count_nxt;
      hold_count_r   <= hold_count_nxt;
    end
  end

  // Steer results into the output register or park them in the skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_acc;
        out_data_nxt  = res;
      end
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  // A parked result always sits behind a pending output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while output register is empty");

  // A sampled tick restarts the sample counter
  a_sample_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && do_sample) |=> (sample_count_r == '0))
    else $error("sample counter not cleared after a sample");

  // A press event restarts the hold counter and enters the pressed class
  a_press_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.event_raised == EV_PRESSED)
      |=> (hold_count_r == '0 && press_class_r == CLS_PRESSED))
    else $error("press event did not restart hold counter");

  // A long press event only ever leaves the pressed class
  a_long_from_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.event_raised == EV_LONG) |-> (press_class_r == CLS_PRESSED))
    else $error("long press raised outside the pressed class");

  // No event without a sample
  a_event_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.event_raised != EV_NONE) |-> out_data_r.sampled_now)
    else $error("event raised on a tick without a sample");

endmodule

`default_nettype wire
